[sv/ssm_pkg.sv]
package ssm_pkg;

  // Sizes of the id space, of dense positions and of the member count.
  localparam int ENTITY_IDS = 1024;
  localparam int ID_W       = 10;
  localparam int CNT_W      = 11;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2,
    ST_RSVD = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_FIX
  } state_t;

  // One map entry: presence flag and dense position.
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] pos;
  } map_entry_t;

  typedef struct packed {
    op_t             opcode;
    logic [ID_W-1:0] entity_id;
    logic [ID_W-1:0] list_position;
  } request_t;

  typedef struct packed {
    logic             is_member;
    logic [ID_W-1:0]  member_position;
    logic [ID_W-1:0]  entry_id;
    logic [CNT_W-1:0] member_count;
    status_t          status;
  } response_t;

endpackage

[sv/sparse_set_membership_table.sv]
// Sparse-set membership table over 10-bit entity ids.
//
// Commands enter on request and are taken at a clock edge where start is high
// and busy is low. Each command gives exactly one transfer on response, marked
// by done for a single cycle; the receiver cannot hold it off.
// Add, query and read pass through the lookup state; done rises as the block
// returns to idle, and busy falls in that same cycle, so the next command can
// be taken while done is high. Remove also passes through the fix state,
// since it needs a second write to the position map after the moved member's
// entry has been updated. Commands do not overlap, since the position map and
// dense list memories each have one write port and one registered read port:
// one read, then the writes, then the next command's read.
// After reset the block runs a clearing pass over the position map, one entry
// per cycle, with busy high; the member count starts at zero.
// The dense list is never cleared: only positions below the count are read.
module sparse_set_membership_table (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ssm_pkg::request_t  request,
  output logic               busy,
  output logic               done,
  output ssm_pkg::response_t response
);

  import ssm_pkg::*;

  state_t           state, state_next;
  logic [ID_W-1:0]  clr_addr;
  logic [CNT_W-1:0] count, count_next;
  request_t         req_q;
  response_t        resp_next;
  logic             done_next;

  logic             map_we;
  logic [ID_W-1:0]  map_waddr, map_raddr;
  map_entry_t       map_wdata, map_rdata;
  logic             dense_we;
  logic [ID_W-1:0]  dense_waddr, dense_raddr, dense_wdata, dense_rdata;
  logic [CNT_W-1:0] count_m1;

  assign count_m1 = count - CNT_W'(1);
  assign busy     = (state != S_IDLE);

  ssm_ram #(.ADDR_W(ID_W), .DATA_W(ID_W + 1)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  ssm_ram #(.ADDR_W(ID_W), .DATA_W(ID_W)) u_dense (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: clear pointer, count and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + ID_W'(1);
      end
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers: accepted command and result.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_q <= request;
    end
    response <= resp_next;
  end

  // Next state, memory accesses and result.
  always_comb begin
    state_next  = state;
    count_next  = count;
    done_next   = 1'b0;
    resp_next   = '0;
    map_we      = 1'b0;
    map_waddr   = req_q.entity_id;
    map_wdata   = '0;
    map_raddr   = request.entity_id;
    dense_we    = 1'b0;
    dense_waddr = map_rdata.pos;
    dense_wdata = dense_rdata;
    dense_raddr = (request.opcode == OP_READ) ? request.list_position
                                              : count_m1[ID_W-1:0];

    unique case (state)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_addr;
        if (&clr_addr) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          state_next = S_LOOKUP;
        end
      end

      S_LOOKUP: begin
        state_next             = S_IDLE;
        done_next              = 1'b1;
        resp_next.member_count = count;
        resp_next.status       = ST_OK;
        unique case (req_q.opcode)
          OP_ADD: begin
            if (map_rdata.valid) begin
              resp_next.is_member       = 1'b1;
              resp_next.member_position = map_rdata.pos;
            end else if (count >= CNT_W'(ENTITY_IDS)) begin
              resp_next.status = ST_FULL;
            end else begin
              // Append at the tail of the dense list.
              dense_we                  = 1'b1;
              dense_waddr               = count[ID_W-1:0];
              dense_wdata               = req_q.entity_id;
              map_we                    = 1'b1;
              map_waddr                 = req_q.entity_id;
              map_wdata.valid           = 1'b1;
              map_wdata.pos             = count[ID_W-1:0];
              count_next                = count + CNT_W'(1);
              resp_next.is_member       = 1'b1;
              resp_next.member_position = count[ID_W-1:0];
              resp_next.member_count    = count + CNT_W'(1);
            end
          end

          OP_REMOVE: begin
            if (!map_rdata.valid || count == '0) begin
              resp_next.status = ST_MISS;
            end else begin
              // Move the last member into the hole and repoint its entry.
              // The removed id's own entry is cleared in the next cycle,
              // which also covers removing the last member itself.
              dense_we        = 1'b1;
              dense_waddr     = map_rdata.pos;
              dense_wdata     = dense_rdata;
              map_we          = 1'b1;
              map_waddr       = dense_rdata;
              map_wdata.valid = 1'b1;
              map_wdata.pos   = map_rdata.pos;
              count_next      = count_m1;
              done_next       = 1'b0;
              state_next      = S_FIX;
            end
          end

          OP_QUERY: begin
            if (map_rdata.valid) begin
              resp_next.is_member       = 1'b1;
              resp_next.member_position = map_rdata.pos;
            end
          end

          OP_READ: begin
            if ({1'b0, req_q.list_position} < count) begin
              resp_next.entry_id = dense_rdata;
            end else begin
              resp_next.status = ST_MISS;
            end
          end

          default: begin
            resp_next.status = ST_MISS;
          end
        endcase
      end

      S_FIX: begin
        map_we                 = 1'b1;
        map_waddr              = req_q.entity_id;
        state_next             = S_IDLE;
        done_next              = 1'b1;
        resp_next.member_count = count;
        resp_next.status       = ST_OK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[sv/ssm_ram.sv]
module ssm_ram #(
  parameter int ADDR_W = 10,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
